// ===== rtl/case_insensitive_substring_matcher_core_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the case-insensitive substring matcher.
// Each macro checks an implication on the rising clock edge, with reset off.
// ----------------------------------------------------------------------------
`ifndef CASE_INSENSITIVE_SUBSTRING_MATCHER_CORE_ASSERT_SVH
`define CASE_INSENSITIVE_SUBSTRING_MATCHER_CORE_ASSERT_SVH

// Same-cycle implication.
`define CISM_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("cism: same-cycle check failed");

// Next-cycle implication.
`define CISM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("cism: next-cycle check failed");

`endif

// ===== rtl/cism_pkg.sv =====
// ----------------------------------------------------------------------------
// cism_pkg
// Shared constants, types and the case-folding function of the matcher.
// ----------------------------------------------------------------------------
`default_nettype none

package cism_pkg;

  // Sizes.
  localparam int MaxPattern   = 32;
  localparam int PatternBytes = 32;
  localparam int NumWords     = 4;
  localparam int LenW         = 6;
  localparam int CmpDepth     = (MaxPattern < PatternBytes) ? MaxPattern : PatternBytes;
  localparam int CntW         = $clog2(MaxPattern + 1);
  localparam int CmpW         = (CntW > LenW) ? CntW : LenW;
  localparam int CfgAddrW     = 3;
  localparam int CfgDataW     = 64;

  // Configuration register indexes.
  localparam logic [CfgAddrW-1:0] CfgWord0  = 3'd0;
  localparam logic [CfgAddrW-1:0] CfgWord1  = 3'd1;
  localparam logic [CfgAddrW-1:0] CfgWord2  = 3'd2;
  localparam logic [CfgAddrW-1:0] CfgWord3  = 3'd3;
  localparam logic [CfgAddrW-1:0] CfgLength = 3'd4;

  typedef logic [7:0] byte_t;

  // Pattern as seen by the compare: aligned so that entry k faces window entry k.
  typedef struct packed {
    byte_t [CmpDepth-1:0] bytes;
    logic  [CmpDepth-1:0] care;
    logic  [LenW-1:0]     len;
    logic                 empty;
    logic                 never;
  } pat_cfg_t;

  // Window stage handed from the input side to the compare stage.
  typedef struct packed {
    logic                 valid;
    byte_t [CmpDepth-1:0] window;
    logic  [CntW-1:0]     cnt;
    logic                 last;
  } stage_t;

  // Folds A-Z to a-z and leaves every other byte alone.
  function automatic byte_t fold_case(input byte_t b);
    byte_t res;
    res = b;
    if (b >= 8'h41 && b <= 8'h5A) begin
      res = b + 8'h20;
    end
    return res;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/cism_text_if.sv =====
// ----------------------------------------------------------------------------
// cism_text_if
// Text channel: one raw byte and its line-end flag per transaction.
// ----------------------------------------------------------------------------
`default_nettype none

interface cism_text_if;
  logic                valid;
  logic                ready;
  cism_pkg::byte_t     text_byte;
  logic                line_end;

  modport source (output valid, output text_byte, output line_end, input ready);
  modport sink   (input valid, input text_byte, input line_end, output ready);
endinterface

`default_nettype wire

// ===== rtl/cism_result_if.sv =====
// ----------------------------------------------------------------------------
// cism_result_if
// Result channel: match flags for one text byte per transaction.
// ----------------------------------------------------------------------------
`default_nettype none

interface cism_result_if;
  logic valid;
  logic ready;
  logic match_here;
  logic line_has_match;
  logic line_done;

  modport source (output valid, output match_here, output line_has_match,
                  output line_done, input ready);
  modport sink   (input valid, input match_here, input line_has_match,
                  input line_done, output ready);
endinterface

`default_nettype wire

// ===== rtl/case_insensitive_substring_matcher_core.sv =====
// ----------------------------------------------------------------------------
// case_insensitive_substring_matcher_core
// Reports, for each text byte, whether the case-folded pattern ends there,
// and whether any match has occurred so far in the current line.
//
//   Port      Direction  Transaction carries
//   in_chan   sink       text_byte, line_end
//   out_chan  source     match_here, line_has_match, line_done
//   cfg_*     write      pattern words 0..3, pattern length
//
// One byte is accepted every cycle while out_chan is ready; each byte passes
// the input register, then the window compare and the result register.
// The window compare checks 32 window bytes in parallel, combinationally.
// Reset clears the stage valids, line byte count, hit flag and cfg registers.
// When out_chan stalls, both stages hold; in_chan.ready drops only when both
// are full and out_chan is not ready.
// ----------------------------------------------------------------------------
`default_nettype none

`include "case_insensitive_substring_matcher_core_assert.svh"

module case_insensitive_substring_matcher_core (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  cism_text_if.sink                          in_chan,
  cism_result_if.source                      out_chan,
  input  wire logic                          cfg_we,
  input  wire logic [cism_pkg::CfgAddrW-1:0] cfg_addr,
  input  wire logic [cism_pkg::CfgDataW-1:0] cfg_wdata
);

  cism_pkg::pat_cfg_t pat_cfg;
  cism_pkg::stage_t   stage;
  logic               take;
  logic               accept;

  // Input side is free when the stage is empty or moving on.
  assign in_chan.ready = !stage.valid || take;
  assign accept        = in_chan.valid && in_chan.ready;

  cism_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .pat_cfg   (pat_cfg)
  );

  cism_window u_window (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .take      (take),
    .text_byte (in_chan.text_byte),
    .line_end  (in_chan.line_end),
    .stage     (stage)
  );

  cism_match_out u_match (
    .clk      (clk),
    .rst_n    (rst_n),
    .stage    (stage),
    .pat_cfg  (pat_cfg),
    .take     (take),
    .out_chan (out_chan)
  );

  // A stalled stage keeps its window, count and flags.
  `CISM_ASSERT_NEXT(a_stage_hold, clk, rst_n, stage.valid && !take, $stable(stage))
  // A match always shows in the line flag.
  `CISM_ASSERT_NOW(a_hit_sticky, clk, rst_n,
                   out_chan.valid && out_chan.match_here, out_chan.line_has_match)
  // An empty pattern matches every byte.
  `CISM_ASSERT_NEXT(a_empty_match, clk, rst_n, stage.valid && take && pat_cfg.empty,
                    out_chan.match_here)
  // The line byte count never passes its saturation point.
  `CISM_ASSERT_NOW(a_cnt_range, clk, rst_n, stage.valid,
                   stage.cnt <= cism_pkg::CntW'(cism_pkg::MaxPattern))

endmodule

`default_nettype wire

// ===== rtl/cism_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// cism_cfg_regs
// Pattern and length registers, plus the registered, case-folded and
// end-aligned copy of the pattern that the compare stage uses.
// ----------------------------------------------------------------------------
`default_nettype none

module cism_cfg_regs (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              cfg_we,
  input  wire logic [cism_pkg::CfgAddrW-1:0]     cfg_addr,
  input  wire logic [cism_pkg::CfgDataW-1:0]     cfg_wdata,
  output cism_pkg::pat_cfg_t                     pat_cfg
);

  logic [cism_pkg::NumWords-1:0][cism_pkg::CfgDataW-1:0] word_r;
  logic [cism_pkg::LenW-1:0]                             len_r;
  cism_pkg::pat_cfg_t                                    pat_r;
  cism_pkg::pat_cfg_t                                    pat_nxt;

  logic [cism_pkg::PatternBytes*8-1:0] flat;
  logic [cism_pkg::PatternBytes*8-1:0] rev;
  logic [cism_pkg::PatternBytes*8-1:0] shifted;
  logic [cism_pkg::LenW-1:0]           sh;

  // Register writes; indexes past the list are ignored.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      word_r <= '0;
      len_r  <= '0;
    end else if (cfg_we) begin
      case (cfg_addr)
        cism_pkg::CfgWord0:  word_r[0] <= cfg_wdata;
        cism_pkg::CfgWord1:  word_r[1] <= cfg_wdata;
        cism_pkg::CfgWord2:  word_r[2] <= cfg_wdata;
        cism_pkg::CfgWord3:  word_r[3] <= cfg_wdata;
        cism_pkg::CfgLength: len_r     <= cfg_wdata[cism_pkg::LenW-1:0];
        default: ;
      endcase
    end
  end

  // Fold and reverse the pattern, then shift it so that its last byte lands
  // on entry 0, which faces the newest text byte.
  always_comb begin
    flat = word_r;
    for (int j = 0; j < cism_pkg::PatternBytes; j++) begin
      rev[j*8 +: 8] = cism_pkg::fold_case(flat[(cism_pkg::PatternBytes-1-j)*8 +: 8]);
    end
    sh      = cism_pkg::LenW'(cism_pkg::PatternBytes) - len_r;
    shifted = rev >> {sh, 3'b000};

    for (int k = 0; k < cism_pkg::CmpDepth; k++) begin
      pat_nxt.bytes[k] = shifted[k*8 +: 8];
      pat_nxt.care[k]  = cism_pkg::LenW'(k) < len_r;
    end
    pat_nxt.len   = len_r;
    pat_nxt.empty = (len_r == '0);
    pat_nxt.never = (len_r > cism_pkg::LenW'(cism_pkg::CmpDepth));
  end

  // The aligned copy follows the registers in the next cycle. With no entry
  // cared for and a zero length, the cleared copy still matches every byte.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pat_r <= '0;
    end else begin
      pat_r <= pat_nxt;
    end
  end

  assign pat_cfg = pat_r;

endmodule

`default_nettype wire

// ===== rtl/cism_window.sv =====
// ----------------------------------------------------------------------------
// cism_window
// Input register stage: folds each accepted byte into the recent-byte window
// and tracks how many bytes of the current line have been seen.
// ----------------------------------------------------------------------------
`default_nettype none

module cism_window (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            accept,
  input  wire logic            take,
  input  wire cism_pkg::byte_t text_byte,
  input  wire logic            line_end,
  output cism_pkg::stage_t     stage
);

  logic                                   valid_r;
  logic                                   valid_nxt;
  cism_pkg::byte_t [cism_pkg::CmpDepth-1:0] window_r;
  cism_pkg::byte_t [cism_pkg::CmpDepth-1:0] window_nxt;
  logic [cism_pkg::CntW-1:0]              cnt_r;
  logic [cism_pkg::CntW-1:0]              cnt_inc;
  logic [cism_pkg::CntW-1:0]              stage_cnt_r;
  logic                                   last_r;

  // Shift in the folded byte, newest at entry 0; count saturates.
  always_comb begin
    window_nxt[0] = cism_pkg::fold_case(text_byte);
    for (int k = 1; k < cism_pkg::CmpDepth; k++) begin
      window_nxt[k] = window_r[k-1];
    end
    if (cnt_r < cism_pkg::CntW'(cism_pkg::MaxPattern)) begin
      cnt_inc = cism_pkg::CntW'(cnt_r + 1'b1);
    end else begin
      cnt_inc = cnt_r;
    end
    if (accept) begin
      valid_nxt = 1'b1;
    end else if (take) begin
      valid_nxt = 1'b0;
    end else begin
      valid_nxt = valid_r;
    end
  end

  // Control state: stage valid and the line byte count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      cnt_r   <= '0;
    end else begin
      valid_r <= valid_nxt;
      if (accept) begin
        cnt_r <= line_end ? '0 : cnt_inc;
      end
    end
  end

  // Payload of the stage, loaded only on a transaction.
  always_ff @(posedge clk) begin
    if (accept) begin
      window_r    <= window_nxt;
      stage_cnt_r <= cnt_inc;
      last_r      <= line_end;
    end
  end

  assign stage.valid  = valid_r;
  assign stage.window = window_r;
  assign stage.cnt    = stage_cnt_r;
  assign stage.last   = last_r;

endmodule

`default_nettype wire

// ===== rtl/cism_match_out.sv =====
// ----------------------------------------------------------------------------
// cism_match_out
// Parallel window compare, per-line sticky hit flag and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module cism_match_out (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire cism_pkg::stage_t   stage,
  input  wire cism_pkg::pat_cfg_t pat_cfg,
  output logic                    take,
  cism_result_if.source           out_chan
);

  logic [cism_pkg::CmpDepth-1:0] eq;
  logic                          cnt_ok;
  logic                          match;
  logic                          hit_r;
  logic                          hit_nxt;
  logic                          out_valid_r;
  logic                          match_r;
  logic                          line_hit_r;
  logic                          done_r;

  // Every cared-for entry must agree, and the line must hold enough bytes.
  always_comb begin
    for (int k = 0; k < cism_pkg::CmpDepth; k++) begin
      eq[k] = (stage.window[k] == pat_cfg.bytes[k]) || !pat_cfg.care[k];
    end
    cnt_ok  = cism_pkg::CmpW'(stage.cnt) >= cism_pkg::CmpW'(pat_cfg.len);
    match   = pat_cfg.empty || (!pat_cfg.never && cnt_ok && (&eq));
    hit_nxt = hit_r | match;
  end

  assign take = !out_valid_r || out_chan.ready;

  // Control state: result valid and the sticky line flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      hit_r       <= 1'b0;
    end else if (take) begin
      out_valid_r <= stage.valid;
      if (stage.valid) begin
        hit_r <= stage.last ? 1'b0 : hit_nxt;
      end
    end
  end

  // Result payload.
  always_ff @(posedge clk) begin
    if (take && stage.valid) begin
      match_r    <= match;
      line_hit_r <= hit_nxt;
      done_r     <= stage.last;
    end
  end

  assign out_chan.valid          = out_valid_r;
  assign out_chan.match_here     = match_r;
  assign out_chan.line_has_match = line_hit_r;
  assign out_chan.line_done      = done_r;

endmodule

`default_nettype wire
